@@ rtl/cmapf4_pkg.sv @@
// Shared types and codes for the character-map segment lookup.
`default_nettype none
package cmapf4_pkg;

    typedef enum logic [1:0] {
        ACT_WR_SEGMENT = 2'd0,
        ACT_WR_GLYPH   = 2'd1,
        ACT_LOOKUP     = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        STAT_FOUND     = 2'd0,
        STAT_NO_SEG    = 2'd1,
        STAT_OUT_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAIN,
        ST_RANGE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        KIND_MISS,
        KIND_DIRECT,
        KIND_ARRAY,
        KIND_OUT_RANGE
    } t_kind;

    typedef struct packed {
        logic [15:0] start_code;
        logic [15:0] end_code;
        logic [15:0] delta;
        logic [15:0] range_offset;
    } t_seg_entry;

    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [15:0] code;
        t_seg_entry  entry;
    } t_token;

endpackage
`default_nettype wire

@@ rtl/cmapf4_if.sv @@
// Valid/ready channel interfaces for lookup items and results.
`default_nettype none
interface cmapf4_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [7:0]         entry_index;
    logic [15:0]        seg_start_code;
    logic [15:0]        seg_end_code;
    logic signed [15:0] seg_delta;
    logic [15:0]        seg_range_offset;
    logic [15:0]        glyph_word;
    logic [15:0]        char_code;

    modport source (
        output valid, action, entry_index, seg_start_code, seg_end_code, seg_delta,
               seg_range_offset, glyph_word, char_code,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, seg_start_code, seg_end_code, seg_delta,
               seg_range_offset, glyph_word, char_code,
        output ready
    );
endinterface

interface cmapf4_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] glyph;
    logic [1:0]  status;

    modport source (output valid, glyph, status, input ready);
    modport sink (input valid, glyph, status, output ready);
endinterface
`default_nettype wire

@@ rtl/cmapf4_cell.sv @@
// One segment cell of the search chain: holds an entry and matches a passing token.
`default_nettype none
module cmapf4_cell #(
    parameter int SEG_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_wr_en,
    input  wire cmapf4_pkg::t_seg_entry i_wr_entry,
    input  wire                         i_active,
    input  wire cmapf4_pkg::t_token     i_tok,
    input  wire  [SEG_W-1:0]            i_seg,
    output cmapf4_pkg::t_token          o_tok,
    output logic [SEG_W-1:0]            o_seg
);

    cmapf4_pkg::t_seg_entry r_entry;
    cmapf4_pkg::t_token     r_tok;
    cmapf4_pkg::t_token     n_tok;
    logic [SEG_W-1:0]       r_seg;
    logic [SEG_W-1:0]       n_seg;
    logic                   match;

    always_comb begin
        match = i_tok.valid && !i_tok.hit && i_active
                && (i_tok.code >= r_entry.start_code) && (i_tok.code <= r_entry.end_code);
        n_tok = i_tok;
        n_seg = i_seg;
        if (match) begin
            n_tok.hit   = 1'b1;
            n_tok.entry = r_entry;
            n_seg       = SEG_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.hit   <= n_tok.hit;
        r_tok.code  <= n_tok.code;
        r_tok.entry <= n_tok.entry;
        r_seg       <= n_seg;
        if (i_wr_en) begin
            r_entry <= i_wr_entry;
        end
    end

    assign o_tok = r_tok;
    assign o_seg = r_seg;

endmodule
`default_nettype wire

@@ rtl/cmap_format4_glyph_lookup.sv @@
// Top level of the character-map format 4 glyph lookup with its segment cell chain.
// A write beat takes effect at its accepting edge. A lookup token walks one cell a cycle
// down the segment chain; then the sum and kind are registered, the glyph array is read in
// the range state and the result is registered in the done state once the output is free.
// Beats are taken only while idle, one write per cycle, so lookups never overlap.
// Reset clears control state and sets the segment count to one; tables are undefined.
`default_nettype none
module cmap_format4_glyph_lookup #(
    parameter int MAX_SEGMENTS      = 64,
    parameter int GLYPH_ARRAY_WORDS = 256
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    cmapf4_in_if.sink        i_lookup,
    cmapf4_out_if.source     o_result,
    input  wire              i_cfg_wr_en,
    input  wire  [6:0]       i_cfg_wr_data
);

    localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int ADDR_W = (GLYPH_ARRAY_WORDS > 1) ? $clog2(GLYPH_ARRAY_WORDS) : 1;
    localparam int SUM_W  = 18;

    cmapf4_pkg::t_state     r_state;
    cmapf4_pkg::t_state     n_state;
    logic [6:0]             r_seg_count;
    logic [CNT_W-1:0]       seg_used;

    cmapf4_pkg::t_token     tok [0:MAX_SEGMENTS];
    logic [SEG_W-1:0]       seg [0:MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] chain_valid;
    cmapf4_pkg::t_seg_entry wr_entry;

    logic [15:0]            glyph_mem [0:GLYPH_ARRAY_WORDS-1];
    logic [15:0]            r_word;

    logic                   accept;
    logic                   out_free;
    cmapf4_pkg::t_token     last_tok;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       idx;
    cmapf4_pkg::t_kind      r_kind;
    logic [15:0]            r_code;
    logic [15:0]            r_delta;

    logic                   r_out_valid;
    logic [15:0]            r_out_glyph;
    cmapf4_pkg::t_status    r_out_status;

    assign accept   = i_lookup.valid && i_lookup.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign last_tok = tok[MAX_SEGMENTS];

    always_comb begin
        if (32'(r_seg_count) > MAX_SEGMENTS) begin
            seg_used = CNT_W'(MAX_SEGMENTS);
        end else begin
            seg_used = CNT_W'(r_seg_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= 7'd1;
        end else if (i_cfg_wr_en) begin
            r_seg_count <= i_cfg_wr_data;
        end
    end

    always_comb begin
        tok[0].valid = accept && (i_lookup.action == cmapf4_pkg::ACT_LOOKUP);
        tok[0].hit   = 1'b0;
        tok[0].code  = i_lookup.char_code;
        tok[0].entry = '0;
        seg[0]       = '0;
        wr_entry.start_code   = i_lookup.seg_start_code;
        wr_entry.end_code     = i_lookup.seg_end_code;
        wr_entry.delta        = 16'(i_lookup.seg_delta);
        wr_entry.range_offset = i_lookup.seg_range_offset;
    end

    for (genvar gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
        logic cell_wr;
        assign cell_wr = accept && (i_lookup.action == cmapf4_pkg::ACT_WR_SEGMENT)
                         && (16'(i_lookup.entry_index) == 16'(gi));
        cmapf4_cell #(
            .SEG_W    (SEG_W),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (cell_wr),
            .i_wr_entry (wr_entry),
            .i_active   (CNT_W'(gi) < seg_used),
            .i_tok      (tok[gi]),
            .i_seg      (seg[gi]),
            .o_tok      (tok[gi+1]),
            .o_seg      (seg[gi+1])
        );
        assign chain_valid[gi] = tok[gi+1].valid;
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_lookup.action == cmapf4_pkg::ACT_WR_GLYPH)
            && (32'(i_lookup.entry_index) < GLYPH_ARRAY_WORDS)) begin
            glyph_mem[ADDR_W'(i_lookup.entry_index)] <= i_lookup.glyph_word;
        end
        if (r_state == cmapf4_pkg::ST_RANGE) begin
            r_word <= glyph_mem[idx[ADDR_W-1:0]];
        end
    end

    assign idx = r_sum - SUM_W'(seg_used);

    always_ff @(posedge i_clk) begin
        if (r_state == cmapf4_pkg::ST_CHAIN && last_tok.valid) begin
            r_sum   <= SUM_W'(last_tok.entry.range_offset[15:1])
                       + SUM_W'(16'(last_tok.code - last_tok.entry.start_code))
                       + SUM_W'(seg[MAX_SEGMENTS]);
            r_code  <= last_tok.code;
            r_delta <= last_tok.entry.delta;
            if (!last_tok.hit) begin
                r_kind <= cmapf4_pkg::KIND_MISS;
            end else if (last_tok.entry.range_offset == 16'd0) begin
                r_kind <= cmapf4_pkg::KIND_DIRECT;
            end else begin
                r_kind <= cmapf4_pkg::KIND_ARRAY;
            end
        end else if (r_state == cmapf4_pkg::ST_RANGE && r_kind == cmapf4_pkg::KIND_ARRAY) begin
            if (r_sum < SUM_W'(seg_used) || 32'(idx) >= GLYPH_ARRAY_WORDS) begin
                r_kind <= cmapf4_pkg::KIND_OUT_RANGE;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cmapf4_pkg::ST_IDLE: begin
                if (accept && i_lookup.action == cmapf4_pkg::ACT_LOOKUP) begin
                    n_state = cmapf4_pkg::ST_CHAIN;
                end
            end
            cmapf4_pkg::ST_CHAIN: begin
                if (last_tok.valid) begin
                    n_state = cmapf4_pkg::ST_RANGE;
                end
            end
            cmapf4_pkg::ST_RANGE: n_state = cmapf4_pkg::ST_DONE;
            cmapf4_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = cmapf4_pkg::ST_IDLE;
                end
            end
            default: n_state = cmapf4_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmapf4_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_lookup.ready = (r_state == cmapf4_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == cmapf4_pkg::ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cmapf4_pkg::ST_DONE && out_free) begin
            case (r_kind)
                cmapf4_pkg::KIND_MISS: begin
                    r_out_glyph  <= 16'd0;
                    r_out_status <= cmapf4_pkg::STAT_NO_SEG;
                end
                cmapf4_pkg::KIND_DIRECT: begin
                    r_out_glyph  <= r_code + r_delta;
                    r_out_status <= cmapf4_pkg::STAT_FOUND;
                end
                cmapf4_pkg::KIND_ARRAY: begin
                    r_out_glyph  <= (r_word != 16'd0) ? r_word + r_delta : 16'd0;
                    r_out_status <= cmapf4_pkg::STAT_FOUND;
                end
                default: begin
                    r_out_glyph  <= 16'd0;
                    r_out_status <= cmapf4_pkg::STAT_OUT_RANGE;
                end
            endcase
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.glyph  = r_out_glyph;
    assign o_result.status = r_out_status;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(chain_valid) <= 1)
        else $error("More than one lookup token in the segment chain.");

    a_accept_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (chain_valid == '0))
        else $error("Beat accepted while a lookup was still in the chain.");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(r_state == cmapf4_pkg::ST_DONE))
        else $error("Result raised outside the completion state.");

    a_chain_enters_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmapf4_pkg::ST_CHAIN && last_tok.valid) |=>
            (r_state == cmapf4_pkg::ST_RANGE))
        else $error("Chain output not followed by the range stage.");

endmodule
`default_nettype wire
